[rtl/jhip_pkg.sv]
// Package for the JPEG header info parser: payload structs, status and phase codes,
// marker constants and marker classification functions.
// Depends on nothing; every other file of the block imports it.
package jhip_pkg;

    localparam int CounterBitsDefault = 16;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UNSUP   = 3'd1;
    localparam logic [2:0] ST_MAGIC   = 3'd2;
    localparam logic [2:0] ST_TRUNC   = 3'd3;
    localparam logic [2:0] ST_CORRUPT = 3'd4;
    localparam logic [2:0] ST_LARGE   = 3'd5;

    localparam logic [3:0] PH_MAGIC  = 4'd0;
    localparam logic [3:0] PH_SEEK   = 4'd1;
    localparam logic [3:0] PH_FILL   = 4'd2;
    localparam logic [3:0] PH_LENHI  = 4'd3;
    localparam logic [3:0] PH_LENLO  = 4'd4;
    localparam logic [3:0] PH_SOF0   = 4'd5;
    localparam logic [3:0] PH_SOF1   = 4'd6;
    localparam logic [3:0] PH_SOF2   = 4'd7;
    localparam logic [3:0] PH_SOF3   = 4'd8;
    localparam logic [3:0] PH_SOF4   = 4'd9;
    localparam logic [3:0] PH_SOF5   = 4'd10;
    localparam logic [3:0] PH_SKIP   = 4'd11;
    localparam logic [3:0] PH_SCAN   = 4'd12;
    localparam logic [3:0] PH_SCANFF = 4'd13;
    localparam logic [3:0] PH_DONE   = 4'd14;

    localparam logic [1:0] CFG_METADATA_ONLY = 2'd0;
    localparam logic [1:0] CFG_MAX_WIDTH     = 2'd1;
    localparam logic [1:0] CFG_MAX_HEIGHT    = 2'd2;

    localparam logic [7:0] MK_FILL  = 8'hFF;
    localparam logic [7:0] MK_ZERO  = 8'h00;
    localparam logic [7:0] MK_TEM   = 8'h01;
    localparam logic [7:0] MK_SOI   = 8'hD8;
    localparam logic [7:0] MK_EOI   = 8'hD9;
    localparam logic [7:0] MK_SOS   = 8'hDA;
    localparam logic [7:0] MK_RST0  = 8'hD0;
    localparam logic [7:0] MK_DHT   = 8'hC4;
    localparam logic [7:0] MK_JPG   = 8'hC8;
    localparam logic [7:0] MK_DAC   = 8'hCC;
    localparam logic [7:0] MK_APP0  = 8'hE0;
    localparam logic [7:0] MK_APP15 = 8'hEF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  precision;
        logic [7:0]  components;
        logic [15:0] pixel_bits;
        logic [15:0] scan_total;
        logic [15:0] app_total;
        logic [15:0] marker_total;
    } t_out;

    // Parser state captured at the last byte of a file.
    typedef struct packed {
        logic        start_full;
        logic [2:0]  error_code;
        logic [3:0]  phase;
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  precision;
        logic [7:0]  components;
    } t_snap;

    function automatic logic is_sof(input logic [7:0] m);
        return (m[7:4] == 4'hC) && (m != MK_DHT) && (m != MK_JPG) && (m != MK_DAC);
    endfunction

    function automatic logic is_standalone(input logic [7:0] m);
        return (m == MK_TEM) || ((m >= MK_RST0) && (m <= MK_EOI));
    endfunction

endpackage

[rtl/jpeg_header_info_parser.sv]
// Top level of the JPEG header info parser: byte parser followed by the result stage.
// Depends on jhip_pkg, jhip_parser and jhip_result.
//
// The block accepts one file byte per clock cycle as a transaction while it is not stalled,
// and updates the marker and segment state once per accepted byte. On the byte flagged
// as last, the parse state is captured into a snapshot register and cleared for the next
// file; the status and header fields are then judged against the configuration and
// written to the output register as soon as that register is free or being taken, so a
// result passes the snapshot and output registers before it is offered. Bytes keep
// flowing while one result waits; once the snapshot and the output register both hold
// results and the output is not taken, every byte stalls until the output register frees.
// Configuration writes take effect at once and should be made between files.
module jpeg_header_info_parser #(
    parameter int COUNTER_BITS = jhip_pkg::CounterBitsDefault
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  jhip_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output jhip_pkg::t_out o_data,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_addr,
    input  logic [15:0]    i_cfg_wdata
);
    import jhip_pkg::*;

    logic                    snap_valid;
    logic                    snap_take;
    t_snap                   snap;
    logic [COUNTER_BITS-1:0] snap_scan;
    logic [COUNTER_BITS-1:0] snap_app;
    logic [COUNTER_BITS-1:0] snap_mark;

    jhip_parser #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data       (i_data),
        .o_snap_valid (snap_valid),
        .i_snap_take  (snap_take),
        .o_snap       (snap),
        .o_scan       (snap_scan),
        .o_app        (snap_app),
        .o_mark       (snap_mark)
    );

    jhip_result #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_result (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_snap_valid (snap_valid),
        .o_snap_take  (snap_take),
        .i_snap       (snap),
        .i_scan       (snap_scan),
        .i_app        (snap_app),
        .i_mark       (snap_mark),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_data       (o_data)
    );

endmodule

[rtl/jhip_parser.sv]
// Byte-level marker and segment parser state, updated once per accepted transaction.
// Captures a snapshot of the parse state at each last byte. Depends on jhip_pkg.
module jhip_parser #(
    parameter int COUNTER_BITS = jhip_pkg::CounterBitsDefault
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  jhip_pkg::t_in             i_data,
    output logic                      o_snap_valid,
    input  logic                      i_snap_take,
    output jhip_pkg::t_snap           o_snap,
    output logic [COUNTER_BITS-1:0]   o_scan,
    output logic [COUNTER_BITS-1:0]   o_app,
    output logic [COUNTER_BITS-1:0]   o_mark
);
    import jhip_pkg::*;

    logic [3:0]              r_phase, n_phase;
    logic [2:0]              r_ssb, n_ssb;
    logic [15:0]             r_rem, n_rem;
    logic [7:0]              r_lenhi, n_lenhi;
    logic [7:0]              r_marker, n_marker;
    logic                    r_sof_short, n_sof_short;
    logic [2:0]              r_err, n_err;
    logic [15:0]             r_width, n_width;
    logic [15:0]             r_height, n_height;
    logic [7:0]              r_prec, n_prec;
    logic [7:0]              r_comp, n_comp;
    logic [COUNTER_BITS-1:0] r_scan, n_scan;
    logic [COUNTER_BITS-1:0] r_app, n_app;
    logic [COUNTER_BITS-1:0] r_mark, n_mark;

    logic                    r_snap_valid;
    t_snap                   r_snap;
    logic [COUNTER_BITS-1:0] r_snap_scan, r_snap_app, r_snap_mark;

    logic        accept;
    logic [7:0]  b;
    logic [15:0] len;
    logic        sof_m;
    logic        do_mark;
    logic        do_seg_end;
    logic        seg_sof;

    assign o_ready = !r_snap_valid || i_snap_take;
    assign accept  = i_valid && o_ready;
    assign b       = i_data.data_byte;
    assign len     = {r_lenhi, b};
    assign sof_m   = is_sof(r_marker);

    always_comb begin
        n_phase     = r_phase;
        n_ssb       = (r_ssb < 3'd4) ? r_ssb + 3'd1 : r_ssb;
        n_rem       = r_rem;
        n_lenhi     = r_lenhi;
        n_marker    = r_marker;
        n_sof_short = r_sof_short;
        n_err       = r_err;
        n_width     = r_width;
        n_height    = r_height;
        n_prec      = r_prec;
        n_comp      = r_comp;
        n_scan      = r_scan;
        n_app       = r_app;
        n_mark      = r_mark;
        do_mark     = 1'b0;
        do_seg_end  = 1'b0;
        seg_sof     = r_sof_short;
        case (r_phase)
            PH_MAGIC: begin
                if (n_ssb == 3'd1) begin
                    if (b != MK_FILL) begin
                        n_err   = ST_MAGIC;
                        n_phase = PH_DONE;
                    end
                end else if (b != MK_SOI) begin
                    n_err   = ST_MAGIC;
                    n_phase = PH_DONE;
                end else begin
                    n_phase = PH_SEEK;
                end
            end
            PH_SEEK: begin
                if (b == MK_FILL) n_phase = PH_FILL;
            end
            PH_FILL: begin
                if (b != MK_FILL) do_mark = 1'b1;
            end
            PH_LENHI: begin
                n_lenhi = b;
                n_phase = PH_LENLO;
            end
            PH_LENLO: begin
                if (len < 16'd2) begin
                    n_err   = ST_TRUNC;
                    n_phase = PH_DONE;
                end else begin
                    n_rem = len - 16'd2;
                    if ((r_marker >= MK_APP0) && (r_marker <= MK_APP15) && (r_app != '1)) begin
                        n_app = r_app + COUNTER_BITS'(1);
                    end
                    if ((r_marker == MK_SOS) && (r_scan != '1)) begin
                        n_scan = r_scan + COUNTER_BITS'(1);
                    end
                    if (sof_m && (len >= 16'd8)) begin
                        n_phase = PH_SOF0;
                    end else begin
                        n_sof_short = sof_m;
                        seg_sof     = sof_m;
                        if (n_rem == 16'd0) do_seg_end = 1'b1;
                        else n_phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                n_rem = r_rem - 16'd1;
                if (n_rem == 16'd0) do_seg_end = 1'b1;
            end
            PH_SCAN: begin
                if (b == MK_FILL) n_phase = PH_SCANFF;
            end
            PH_SCANFF: begin
                if (b == MK_ZERO) n_phase = PH_SCAN;
                else if (b == MK_FILL) n_phase = PH_FILL;
                else do_mark = 1'b1;
            end
            PH_DONE: begin
            end
            PH_SOF0, PH_SOF1, PH_SOF2, PH_SOF3, PH_SOF4, PH_SOF5: begin
                case (r_phase)
                    PH_SOF0: n_prec   = b;
                    PH_SOF1: n_height = {b, 8'h00};
                    PH_SOF2: n_height = {r_height[15:8], b};
                    PH_SOF3: n_width  = {b, 8'h00};
                    PH_SOF4: n_width  = {r_width[15:8], b};
                    default: n_comp   = b;
                endcase
                n_rem = r_rem - 16'd1;
                if (r_phase != PH_SOF5) n_phase = r_phase + 4'd1;
                else if (n_rem == 16'd0) do_seg_end = 1'b1;
                else n_phase = PH_SKIP;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        if (do_mark) begin
            if (r_mark != '1) n_mark = r_mark + COUNTER_BITS'(1);
            n_marker = b;
            if (b == MK_EOI) n_phase = PH_DONE;
            else if (is_standalone(b)) n_phase = PH_SEEK;
            else n_phase = PH_LENHI;
        end
        if (do_seg_end) begin
            if (seg_sof) begin
                n_err   = ST_CORRUPT;
                n_phase = PH_DONE;
            end else if (r_marker == MK_SOS) begin
                n_phase = PH_SCAN;
            end else begin
                n_phase = PH_SEEK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_data.last_byte)) begin
            r_phase     <= PH_MAGIC;
            r_ssb       <= '0;
            r_rem       <= '0;
            r_lenhi     <= '0;
            r_marker    <= '0;
            r_sof_short <= 1'b0;
            r_err       <= ST_OK;
            r_width     <= '0;
            r_height    <= '0;
            r_prec      <= '0;
            r_comp      <= '0;
            r_scan      <= '0;
            r_app       <= '0;
            r_mark      <= '0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_ssb       <= n_ssb;
            r_rem       <= n_rem;
            r_lenhi     <= n_lenhi;
            r_marker    <= n_marker;
            r_sof_short <= n_sof_short;
            r_err       <= n_err;
            r_width     <= n_width;
            r_height    <= n_height;
            r_prec      <= n_prec;
            r_comp      <= n_comp;
            r_scan      <= n_scan;
            r_app       <= n_app;
            r_mark      <= n_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (accept && i_data.last_byte) begin
            r_snap_valid <= 1'b1;
        end else if (i_snap_take) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_data.last_byte) begin
            r_snap.start_full <= (n_ssb == 3'd4);
            r_snap.error_code <= n_err;
            r_snap.phase      <= n_phase;
            r_snap.width      <= n_width;
            r_snap.height     <= n_height;
            r_snap.precision  <= n_prec;
            r_snap.components <= n_comp;
            r_snap_scan       <= n_scan;
            r_snap_app        <= n_app;
            r_snap_mark       <= n_mark;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;
    assign o_scan       = r_snap_scan;
    assign o_app        = r_snap_app;
    assign o_mark       = r_snap_mark;

endmodule

[rtl/jhip_result.sv]
// Configuration registers and the final status and result register of the parser.
// Judges a captured parse snapshot and holds the result until taken. Depends on jhip_pkg.
module jhip_result #(
    parameter int COUNTER_BITS = jhip_pkg::CounterBitsDefault
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_addr,
    input  logic [15:0]             i_cfg_wdata,
    input  logic                    i_snap_valid,
    output logic                    o_snap_take,
    input  jhip_pkg::t_snap         i_snap,
    input  logic [COUNTER_BITS-1:0] i_scan,
    input  logic [COUNTER_BITS-1:0] i_app,
    input  logic [COUNTER_BITS-1:0] i_mark,
    output logic                    o_valid,
    input  logic                    i_ready,
    output jhip_pkg::t_out          o_data
);
    import jhip_pkg::*;

    localparam logic [COUNTER_BITS-1:0] OutMax = COUNTER_BITS'(17'h0FFFF);

    logic        r_metadata_only;
    logic [15:0] r_max_width;
    logic [15:0] r_max_height;
    logic        r_out_valid;
    t_out        r_out;
    t_out        n_out;
    logic [2:0]  status;
    logic        trunc_phase;
    logic        report;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metadata_only <= 1'b1;
            r_max_width     <= 16'hFFFF;
            r_max_height    <= 16'hFFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_METADATA_ONLY: r_metadata_only <= i_cfg_wdata[0];
                CFG_MAX_WIDTH:     r_max_width     <= i_cfg_wdata;
                CFG_MAX_HEIGHT:    r_max_height    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        trunc_phase = i_snap.phase inside {PH_FILL, PH_LENHI, PH_LENLO, PH_SCANFF, PH_SKIP,
                                           PH_MAGIC, [PH_SOF0:PH_SOF5]};
        if (!i_snap.start_full) status = ST_TRUNC;
        else if (i_snap.error_code != ST_OK) status = i_snap.error_code;
        else if (trunc_phase) status = ST_TRUNC;
        else if ((i_snap.width == 16'd0) || (i_snap.height == 16'd0)) status = ST_CORRUPT;
        else if ((i_snap.width > r_max_width) || (i_snap.height > r_max_height)) begin
            status = ST_LARGE;
        end else if (r_metadata_only) status = ST_OK;
        else status = ST_UNSUP;
        report = (status == ST_OK) || (status == ST_UNSUP);

        n_out        = '0;
        n_out.status = status;
        if (report) begin
            n_out.width      = i_snap.width;
            n_out.height     = i_snap.height;
            n_out.precision  = i_snap.precision;
            n_out.components = i_snap.components;
            n_out.pixel_bits = {8'h00, i_snap.precision} * {8'h00, i_snap.components};
            if (i_scan == '0) n_out.scan_total = 16'd1;
            else if (i_scan > OutMax) n_out.scan_total = 16'hFFFF;
            else n_out.scan_total = 16'(i_scan);
            n_out.app_total    = (i_app > OutMax) ? 16'hFFFF : 16'(i_app);
            n_out.marker_total = (i_mark > OutMax) ? 16'hFFFF : 16'(i_mark);
        end
    end

    assign o_snap_take = i_snap_valid && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_snap_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_snap_take) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

[rtl/jhip_checker.sv]
// Port-level checks on the results of the JPEG header info parser, bound to its top level.
// Depends on jhip_pkg and jpeg_header_info_parser.
module jhip_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_valid,
    input logic           i_ready,
    input jhip_pkg::t_out o_data
);
    import jhip_pkg::*;

    logic err_status;
    logic ok_status;

    assign err_status = (o_data.status == ST_MAGIC) || (o_data.status == ST_TRUNC) ||
                        (o_data.status == ST_CORRUPT) || (o_data.status == ST_LARGE);
    assign ok_status  = (o_data.status == ST_OK) || (o_data.status == ST_UNSUP);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && err_status |-> (o_data.width == '0) && (o_data.height == '0) &&
            (o_data.precision == '0) && (o_data.components == '0) &&
            (o_data.pixel_bits == '0) && (o_data.scan_total == '0) &&
            (o_data.app_total == '0) && (o_data.marker_total == '0))
        else $error("error result carries nonzero fields");

    a_ok_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ok_status |-> (o_data.width != '0) && (o_data.height != '0) &&
            (o_data.scan_total != '0))
        else $error("accepted result with missing size or frame count");

    a_ok_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ok_status |-> (o_data.marker_total != '0))
        else $error("accepted result without any marker");

endmodule

bind jpeg_header_info_parser jhip_checker u_jhip_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
